>>> hw/rtl/ame_pkg.sv
package ame_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned ADDR_W = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned ERR_W  = 2;

   // program space addressed by the jump target
   localparam int unsigned PROG_WORDS = 256;
   localparam int unsigned JT_W       = (PROG_WORDS > 1) ? $clog2(PROG_WORDS) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 4'd1,
      OP_SUB    = 4'd2,
      OP_MUL    = 4'd3,
      OP_DIV    = 4'd4,
      OP_JMP    = 4'd5,
      OP_JMPN   = 4'd6,
      OP_JMPP   = 4'd7,
      OP_JMPZ   = 4'd8,
      OP_COPY   = 4'd9,
      OP_LOAD   = 4'd10,
      OP_STORE  = 4'd11,
      OP_INPUT  = 4'd12,
      OP_OUTPUT = 4'd13,
      OP_STOP   = 4'd14
   } opcode_type;

   localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_OP = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIV0   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic [JT_W-1:0]   jump_target;
      logic [WORD_W-1:0] in_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc_value;
      logic              jump_taken;
      logic              out_valid;
      logic [WORD_W-1:0] out_value;
      logic              is_halted;
      logic [ERR_W-1:0]  error_code;
   } rsp_type;

endpackage

>>> hw/rtl/ame_req_if.sv
interface ame_req_if;
   logic             valid;
   logic             ready;
   ame_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ame_rsp_if.sv
interface ame_rsp_if;
   logic             valid;
   logic             ready;
   ame_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/accumulator_machine_execute.sv
// Execute unit of an accumulator machine. One decoded instruction per request
// on req_chan; one response per request on rsp_chan. After reset the block
// clears its data memory one word per cycle and takes no request meanwhile.
// Then an instruction reads the data word from the synchronous memory,
// executes, writes back and hands the response to the output register; MUL
// first passes through a registered product; DIV runs the radix-2 restoring
// divider that produces one quotient bit per cycle. A new request is taken
// while the previous response still waits in the output register. Addresses
// at or above DATA_WORDS read as zero and writes to them are dropped. After
// STOP every request is answered with is_halted.
module accumulator_machine_execute #(
   parameter int unsigned DATA_WORDS = 256
) (
   input  logic   clock,
   input  logic   reset,
   ame_req_if.sink   req_chan,
   ame_rsp_if.source rsp_chan
);

   localparam int unsigned MEM_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int unsigned CNT_W  = $clog2(DATA_WORDS + 1);
   localparam int unsigned W      = ame_pkg::WORD_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_MUL   = 6'b010000,
      ST_DIV   = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       clr_ff, clr_in;
   ame_pkg::req_type       req_ff, req_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic                   halt_ff, halt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ame_pkg::rsp_type       rsp_ff, rsp_in;
   logic [W-1:0]           mem [DATA_WORDS];
   logic [W-1:0]           rd_data_ff;
   logic                   a_ok_ff, a_ok_in;
   logic                   mem_we;
   logic [MEM_AW-1:0]      mem_wa;
   logic [W-1:0]           mem_wd;
   logic [W-1:0]           prod_ff, prod_in;
   // divider
   logic [W-1:0]           rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]             dcnt_ff, dcnt_in;
   logic                   qneg_ff, qneg_in;
   logic [W:0]             trial;
   logic [W-1:0]           rem_sh, m_word, acc_mag, m_mag;

   // EXEC waits for a free output register, so intake only needs IDLE
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign m_word  = a_ok_ff ? rd_data_ff : '0;
   assign acc_mag = acc_ff[W-1] ? (~acc_ff + 1'b1) : acc_ff;
   assign m_mag   = m_word[W-1] ? (~m_word + 1'b1) : m_word;
   assign rem_sh  = {rem_ff[W-2:0], quo_ff[W-1]};
   assign trial   = {1'b0, rem_sh} - {1'b0, dvs_ff};

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (req_chan.valid && req_chan.ready) begin
         rd_data_ff <= mem[MEM_AW'(req_chan.payload.addr_a)];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      halt_in      = halt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      a_ok_in      = a_ok_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      qneg_in      = qneg_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_ff[MEM_AW-1:0];
      mem_wd       = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CNT_W'(DATA_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               req_in   = req_chan.payload;
               a_ok_in  = 32'(req_chan.payload.addr_a) < 32'(DATA_WORDS);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // data word now in rd_data_ff
            state_in = ST_EXEC;
            prod_in  = acc_ff * m_word;
            if (!halt_ff && req_ff.op == ame_pkg::OP_MUL) begin
               state_in = ST_MUL;
            end else if (!halt_ff && req_ff.op == ame_pkg::OP_DIV && m_word != '0) begin
               rem_in   = '0;
               quo_in   = acc_mag;
               dvs_in   = m_mag;
               qneg_in  = acc_ff[W-1] ^ m_word[W-1];
               dcnt_in  = 6'd0;
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            state_in = ST_EXEC;
         end
         ST_DIV: begin
            // one quotient bit per cycle
            if (trial[W]) begin
               rem_in = rem_sh;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end else begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 6'(W - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in = '0;
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (halt_ff) begin
                  rsp_in.is_halted = 1'b1;
               end else begin
                  case (req_ff.op)
                     ame_pkg::OP_ADD:  acc_in = acc_ff + m_word;
                     ame_pkg::OP_SUB:  acc_in = acc_ff - m_word;
                     ame_pkg::OP_MUL:  acc_in = prod_ff;
                     ame_pkg::OP_DIV: begin
                        if (m_word == '0) begin
                           rsp_in.error_code = ame_pkg::ERR_DIV0;
                        end else begin
                           acc_in = qneg_ff ? (~quo_ff + 1'b1) : quo_ff;
                        end
                     end
                     ame_pkg::OP_JMP:  rsp_in.jump_taken = 1'b1;
                     ame_pkg::OP_JMPN: rsp_in.jump_taken = acc_ff[W-1];
                     ame_pkg::OP_JMPP: rsp_in.jump_taken = !acc_ff[W-1] && acc_ff != '0;
                     ame_pkg::OP_JMPZ: rsp_in.jump_taken = acc_ff == '0;
                     ame_pkg::OP_COPY: begin
                        mem_we = 32'(req_ff.addr_b) < 32'(DATA_WORDS);
                        mem_wa = MEM_AW'(req_ff.addr_b);
                        mem_wd = m_word;
                     end
                     ame_pkg::OP_LOAD: acc_in = m_word;
                     ame_pkg::OP_STORE: begin
                        mem_we = a_ok_ff;
                        mem_wa = MEM_AW'(req_ff.addr_a);
                        mem_wd = acc_ff;
                     end
                     ame_pkg::OP_INPUT: begin
                        mem_we = a_ok_ff;
                        mem_wa = MEM_AW'(req_ff.addr_a);
                        mem_wd = req_ff.in_value;
                     end
                     ame_pkg::OP_OUTPUT: begin
                        rsp_in.out_valid = 1'b1;
                        rsp_in.out_value = m_word;
                     end
                     ame_pkg::OP_STOP: halt_in = 1'b1;
                     default: rsp_in.error_code = ame_pkg::ERR_BAD_OP;
                  endcase
               end
               rsp_in.acc_value = acc_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         acc_ff       <= acc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      a_ok_ff <= a_ok_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      dcnt_ff <= dcnt_in;
      qneg_ff <= qneg_in;
   end

endmodule
